@@ sv/fbfd_pkg.sv @@
// Shared types and constants of the flag byte fill decompressor.
package fbfd_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int unsigned SIZE_W  = 16;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned NFILL_W = 4;

   // Request kind carried in tuser.
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_BYTE  = 1'b1;

   typedef enum logic [1:0] {
      ST_DATA  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_TRUNC = 2'd2
   } status_type;

   // One unit of work for the output side: optional status beats, an optional
   // literal, then a run of fill bytes. Last marks the end of a block.
   typedef struct packed {
      logic                 trunc;
      logic                 empty;
      logic                 lit;
      logic [BYTE_W-1:0]    lit_byte;
      logic [NFILL_W-1:0]   nfill;
      logic [BYTE_W-1:0]    fill_byte;
      logic                 last;
   } cmd_type;

endpackage

@@ sv/flag_byte_fill_decompressor_top.sv @@
// Top level of the flag byte fill decompressor.
//
// The block expands a compressed byte stream into exactly as many bytes as the
// block length register holds. A start request (tuser 0) arms a new block;
// stream bytes (tuser 1) then come as groups of a control byte, a fill byte
// and one literal for each 1 bit of the control byte, read most significant
// bit first, where a 0 bit yields the fill byte. The last byte of a block
// carries tlast. A start while a block is unfinished first returns a
// truncation status beat, and a start with a block length of zero returns an
// empty-request status beat; both carry tlast.
// The front end parses one request beat per clock and queues a command of up
// to eight result beats into a four-entry queue; the back end sends one result
// beat per clock while the result port is ready, through an output register.
// A request is thus taken every cycle while the queue has room, and sustained
// throughput is bounded by the single result port. The first result beat of
// a request passes through the command queue, the current-command register
// and the output register. The block length register takes effect from the
// next request and should be written only while no request or result is in
// flight. There is no clearing pass after reset.
module flag_byte_fill_decompressor_top
   import fbfd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // Request stream.
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] stream_byte
   input  logic [0:0]        req_tuser,   // [0] kind
   // Result stream.
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // [7:0] out_byte
   output logic              rsp_tlast,
   output logic [1:0]        rsp_tuser,   // [1:0] status
   // Configuration write channel for the block length.
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [SIZE_W-1:0] csr_wdata
);

   logic [SIZE_W-1:0] block_len_ff, block_len_in;
   logic              q_full;
   logic              req_accept;
   logic              push;
   cmd_type           push_cmd;
   logic              pop;
   logic              head_valid;
   cmd_type           head_cmd;

   // The size register always takes a write beat.
   assign csr_ready    = 1'b1;
   assign block_len_in = (csr_valid && csr_ready) ? csr_wdata : block_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_len_ff <= '0;
      end else begin
         block_len_ff <= block_len_in;
      end
   end

   // A request beat is taken whenever the command queue has room.
   assign req_tready = !q_full;
   assign req_accept = req_tvalid && req_tready;

   fbfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_kind   (req_tuser[0]),
      .req_byte   (req_tdata),
      .block_len  (block_len_ff),
      .push       (push),
      .cmd        (push_cmd)
   );

   fbfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   fbfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ sv/fbfd_front.sv @@
// Front end: parses the compressed stream and turns each request into a command.
module fbfd_front
   import fbfd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_accept,
   input  logic              req_kind,
   input  logic [BYTE_W-1:0] req_byte,
   input  logic [SIZE_W-1:0] block_len,
   output logic              push,
   output cmd_type           cmd
);

   typedef enum logic [1:0] {PH_IDLE, PH_CONTROL, PH_FILL, PH_LITERAL} phase_type;

   phase_type            phase_ff, phase_in;
   logic [BYTE_W-1:0]    shift_ff, shift_in;
   logic [NFILL_W-1:0]   bits_ff, bits_in;
   logic [BYTE_W-1:0]    fill_ff, fill_in;
   logic [SIZE_W-1:0]    emitted_ff, emitted_in;

   logic                 is_lit;
   logic                 is_fill;
   logic [BYTE_W-1:0]    shift_a;
   logic [NFILL_W-1:0]   bits_a;
   logic [SIZE_W-1:0]    emitted_a;
   logic [NFILL_W-1:0]   zeros;
   logic [NFILL_W-1:0]   lim;
   logic [SIZE_W-1:0]    remain;
   logic [NFILL_W-1:0]   nfill;
   logic [SIZE_W-1:0]    emitted_b;
   logic                 done_b;

   // Leading zeros of a control byte, 8 when it is all zero.
   function automatic logic [NFILL_W-1:0] lead_zeros(input logic [BYTE_W-1:0] v);
      logic [NFILL_W-1:0] n;
      logic               hit;
      n   = NFILL_W'(BYTE_W);
      hit = 1'b0;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
         if (v[i] && !hit) begin
            n   = NFILL_W'(BYTE_W - 1 - i);
            hit = 1'b1;
         end
      end
      return n;
   endfunction

   // Drain arithmetic, shared by the fill and literal phases.
   always_comb begin
      is_lit    = (phase_ff == PH_LITERAL);
      is_fill   = (phase_ff == PH_FILL);
      shift_a   = is_lit ? {shift_ff[BYTE_W-2:0], 1'b0} : shift_ff;
      bits_a    = is_fill ? NFILL_W'(BYTE_W) : (is_lit ? bits_ff - 1'b1 : bits_ff);
      emitted_a = emitted_ff + SIZE_W'(is_lit);
      zeros     = lead_zeros(shift_a);
      lim       = (zeros < bits_a) ? zeros : bits_a;
      remain    = block_len - emitted_a;
      nfill     = (remain < SIZE_W'(lim)) ? remain[NFILL_W-1:0] : lim;
      emitted_b = emitted_a + SIZE_W'(nfill);
      done_b    = (emitted_b >= block_len);
   end

   always_comb begin
      phase_in   = phase_ff;
      shift_in   = shift_ff;
      bits_in    = bits_ff;
      fill_in    = fill_ff;
      emitted_in = emitted_ff;
      push       = 1'b0;
      cmd        = '0;
      if (req_accept) begin
         if (req_kind == KIND_START) begin
            cmd.trunc  = (phase_ff != PH_IDLE);
            cmd.empty  = (block_len == '0);
            cmd.last   = 1'b1;
            push       = cmd.trunc || cmd.empty;
            shift_in   = '0;
            bits_in    = '0;
            fill_in    = '0;
            emitted_in = '0;
            phase_in   = (block_len == '0) ? PH_IDLE : PH_CONTROL;
         end else if (phase_ff == PH_IDLE) begin
            phase_in = PH_IDLE;
         end else if (emitted_ff >= block_len) begin
            // Size was lowered under the running block: end it silently.
            phase_in = PH_IDLE;
         end else begin
            case (phase_ff)
               PH_CONTROL: begin
                  shift_in = req_byte;
                  phase_in = PH_FILL;
               end
               PH_FILL, PH_LITERAL: begin
                  if (is_fill) begin
                     fill_in = req_byte;
                  end
                  cmd.lit       = is_lit;
                  cmd.lit_byte  = req_byte;
                  cmd.nfill     = nfill;
                  cmd.fill_byte = is_fill ? req_byte : fill_ff;
                  cmd.last      = done_b;
                  push          = is_lit || (nfill != '0);
                  shift_in      = shift_a << nfill;
                  bits_in       = bits_a - nfill;
                  emitted_in    = emitted_b;
                  if (done_b) begin
                     phase_in = PH_IDLE;
                  end else if (bits_a == nfill) begin
                     phase_in = PH_CONTROL;
                  end else begin
                     phase_in = PH_LITERAL;
                  end
               end
               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         shift_ff   <= '0;
         bits_ff    <= '0;
         fill_ff    <= '0;
         emitted_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         shift_ff   <= shift_in;
         bits_ff    <= bits_in;
         fill_ff    <= fill_in;
         emitted_ff <= emitted_in;
      end
   end

   a_bits_range: assert property (@(posedge clock) disable iff (reset)
      bits_ff <= NFILL_W'(BYTE_W))
      else $error("control bit count out of range");

   a_last_idles: assert property (@(posedge clock) disable iff (reset)
      push && cmd.last && !cmd.trunc && !cmd.empty |=> phase_ff == PH_IDLE)
      else $error("block ended but parser did not return to idle");

endmodule

@@ sv/fbfd_queue.sv @@
// Small command queue between the parser and the output sequencer.
module fbfd_queue
   import fbfd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in;
   logic [QPTR_W-1:0]   rd_ff, rd_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("command queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("command queue underflow");

endmodule

@@ sv/fbfd_back.sv @@
// Back end: expands commands into result beats through an output register.
module fbfd_back
   import fbfd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  cmd_type           head_cmd,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [BYTE_W-1:0] rsp_tdata,
   output logic              rsp_tlast,
   output logic [1:0]        rsp_tuser
);

   cmd_type             cur_ff, cur_in;
   logic                cur_valid_ff, cur_valid_in;
   logic                out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]   out_byte_ff, out_byte_in;
   logic                out_last_ff, out_last_in;
   status_type          out_status_ff, out_status_in;

   cmd_type             rest;
   logic                rest_empty;
   logic [BYTE_W-1:0]   sel_byte;
   status_type          sel_status;
   logic                out_free;
   logic                fire;

   always_comb begin
      rest       = cur_ff;
      sel_byte   = '0;
      sel_status = ST_DATA;
      if (cur_ff.trunc) begin
         rest.trunc = 1'b0;
         sel_status = ST_TRUNC;
      end else if (cur_ff.empty) begin
         rest.empty = 1'b0;
         sel_status = ST_EMPTY;
      end else if (cur_ff.lit) begin
         rest.lit = 1'b0;
         sel_byte = cur_ff.lit_byte;
      end else begin
         rest.nfill = cur_ff.nfill - 1'b1;
         sel_byte   = cur_ff.fill_byte;
      end
      rest_empty = !rest.trunc && !rest.empty && !rest.lit && (rest.nfill == '0);

      out_free = !out_valid_ff || rsp_tready;
      fire     = cur_valid_ff && out_free;
      pop      = head_valid && (!cur_valid_ff || (fire && rest_empty));

      if (pop) begin
         cur_in       = head_cmd;
         cur_valid_in = 1'b1;
      end else if (fire) begin
         cur_in       = rest;
         cur_valid_in = !rest_empty;
      end else begin
         cur_in       = cur_ff;
         cur_valid_in = cur_valid_ff;
      end

      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      out_status_in = out_status_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      if (fire) begin
         out_valid_in  = 1'b1;
         out_byte_in   = sel_byte;
         out_status_in = sel_status;
         out_last_in   = (sel_status != ST_DATA) || (cur_ff.last && rest_empty);
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      out_byte_ff   <= out_byte_in;
      out_last_ff   <= out_last_in;
      out_status_ff <= out_status_in;
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_status_ff;

   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_status_ff != ST_DATA |-> out_last_ff && out_byte_ff == '0)
      else $error("status beat without last or with nonzero byte");

   a_no_empty_work: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> cur_ff.trunc || cur_ff.empty || cur_ff.lit || cur_ff.nfill != '0)
      else $error("active command holds no beats");

endmodule
